// ----- rtl/sparse_reduced_cost_engine_macros.svh -----
// ----------------------------------------------------------------------------
// sparse_reduced_cost_engine_macros
// Assertion macros used by the reduced-cost engine RTL.
// ----------------------------------------------------------------------------
`ifndef SPARSE_REDUCED_COST_ENGINE_MACROS_SVH
`define SPARSE_REDUCED_COST_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SRCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/srce_pkg.sv -----
// ----------------------------------------------------------------------------
// srce_pkg
// Types and constants of the sparse reduced-cost engine.
// ----------------------------------------------------------------------------
package srce_pkg;

    localparam int ROW_W  = 12;
    localparam int VAL_W  = 32;
    localparam int TAG_W  = 16;
    localparam int ACC_W  = 64;
    localparam int FRAC_W = 16;

    typedef logic        [ROW_W-1:0] t_row;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic        [TAG_W-1:0] t_tag;
    typedef logic signed [ACC_W-1:0] t_acc;

    // command codes of an input word
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TERM  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // stage enables from the pipeline control
    typedef struct packed {
        logic s2_load;   // stage 1 moves into stage 2
        logic s2_term;   // term in stage 2 is accumulated
        logic s2_close;  // close in stage 2 leaves, accumulator clears
        logic s3_load;   // stage 3 captures the difference
        logic out_load;  // output register captures the result
    } t_stage_en;

endpackage

// ----- rtl/srce_ifs.sv -----
// ----------------------------------------------------------------------------
// srce_ifs
// Valid/ready channels of the reduced-cost engine: command in, result out.
// ----------------------------------------------------------------------------
interface srce_in_if;
    import srce_pkg::*;

    logic valid;
    logic ready;
    logic [1:0] cmd;
    t_row row_index;
    t_val dual_price;
    t_val coefficient;
    t_val cost;
    t_tag var_tag;

    modport source (output valid, cmd, row_index, dual_price, coefficient, cost, var_tag,
                    input ready);
    modport sink (input valid, cmd, row_index, dual_price, coefficient, cost, var_tag,
                  output ready);
endinterface

interface srce_out_if;
    import srce_pkg::*;

    logic valid;
    logic ready;
    t_tag out_var;
    t_val reduced_cost;
    logic saturated;

    modport source (output valid, out_var, reduced_cost, saturated, input ready);
    modport sink (input valid, out_var, reduced_cost, saturated, output ready);
endinterface

// ----- rtl/srce_price_mem.sv -----
// ----------------------------------------------------------------------------
// srce_price_mem
// Dual price store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srce_price_mem #(
    parameter int ROWS = 4096,
    parameter int AW   = 12
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  srce_pkg::t_val     i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output srce_pkg::t_val     o_rd_data
);
    import srce_pkg::*;

    t_val r_mem [ROWS];
    t_val r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/srce_mac.sv -----
// ----------------------------------------------------------------------------
// srce_mac
// Product register, saturating Q32.32 accumulator and close difference.
// ----------------------------------------------------------------------------
module srce_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srce_pkg::t_stage_en i_en,
    input  srce_pkg::t_val      i_price,
    input  srce_pkg::t_val      i_coef,
    input  logic                i_row_ok,
    input  srce_pkg::t_val      i_cost,
    input  srce_pkg::t_tag      i_tag,
    output srce_pkg::t_acc      o_diff,
    output logic                o_clip,
    output srce_pkg::t_tag      o_tag
);
    import srce_pkg::*;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    t_acc r_prod;
    t_val r_cost;
    t_tag r_tag;
    t_acc r_sum;
    logic r_sum_clip;

    t_acc n_sum;
    logic sum_ovf;
    t_acc cost_q;
    t_acc diff_raw;
    logic diff_ovf;

    // stage 2 capture: one 32x32 product per term
    always_ff @(posedge i_clk) begin
        if (i_en.s2_load) begin
            r_prod <= i_row_ok ? t_acc'(i_price * i_coef) : '0;
            r_cost <= i_cost;
            r_tag  <= i_tag;
        end
    end

    // saturating add of the product
    always_comb begin
        n_sum   = r_sum + r_prod;
        sum_ovf = (r_sum[ACC_W-1] == r_prod[ACC_W-1]) && (n_sum[ACC_W-1] != r_sum[ACC_W-1]);
        if (sum_ovf) begin
            n_sum = r_sum[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
    end

    // accumulator: add on a term, clear on a close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_sum_clip <= 1'b0;
        end else if (i_en.s2_close) begin
            r_sum      <= '0;
            r_sum_clip <= 1'b0;
        end else if (i_en.s2_term) begin
            r_sum      <= n_sum;
            r_sum_clip <= r_sum_clip | sum_ovf;
        end
    end

    // cost in Q32.32 minus the sum, saturated
    always_comb begin
        cost_q   = {{(ACC_W-VAL_W-FRAC_W){r_cost[VAL_W-1]}}, r_cost, {FRAC_W{1'b0}}};
        diff_raw = cost_q - r_sum;
        diff_ovf = (cost_q[ACC_W-1] != r_sum[ACC_W-1])
                && (diff_raw[ACC_W-1] != cost_q[ACC_W-1]);
        o_diff   = diff_ovf ? (cost_q[ACC_W-1] ? ACC_MIN : ACC_MAX) : diff_raw;
        o_clip   = r_sum_clip | diff_ovf;
    end

    assign o_tag = r_tag;

endmodule

// ----- rtl/srce_round.sv -----
// ----------------------------------------------------------------------------
// srce_round
// Rounds the Q32.32 difference to Q16.16, clips to 32 bits, output register.
// ----------------------------------------------------------------------------
module srce_round (
    input  logic                i_clk,
    input  srce_pkg::t_stage_en i_en,
    input  srce_pkg::t_acc      i_diff,
    input  logic                i_clip,
    input  srce_pkg::t_tag      i_tag,
    output srce_pkg::t_tag      o_var,
    output srce_pkg::t_val      o_cost,
    output logic                o_sat
);
    import srce_pkg::*;

    localparam int Q_W = ACC_W - FRAC_W + 1;

    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    t_acc r_diff;
    logic r_clip;
    t_tag r_tag;
    t_tag r_out_var;
    t_val r_out_cost;
    logic r_out_sat;

    logic signed [Q_W-1:0] q;
    logic q_ovf;
    t_val q_sat;

    // stage 3 capture
    always_ff @(posedge i_clk) begin
        if (i_en.s3_load) begin
            r_diff <= i_diff;
            r_clip <= i_clip;
            r_tag  <= i_tag;
        end
    end

    // round half up, then clip to the 32-bit range
    always_comb begin
        q     = {r_diff[ACC_W-1], r_diff[ACC_W-1:FRAC_W]}
              + {{(Q_W-1){1'b0}}, r_diff[FRAC_W-1]};
        q_ovf = (q[Q_W-1:VAL_W-1] != {(Q_W-VAL_W+1){1'b0}})
             && (q[Q_W-1:VAL_W-1] != {(Q_W-VAL_W+1){1'b1}});
        q_sat = q_ovf ? (q[Q_W-1] ? VAL_MIN : VAL_MAX) : q[VAL_W-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_en.out_load) begin
            r_out_var  <= r_tag;
            r_out_cost <= q_sat;
            r_out_sat  <= r_clip | q_ovf;
        end
    end

    assign o_var  = r_out_var;
    assign o_cost = r_out_cost;
    assign o_sat  = r_out_sat;

endmodule

// ----- rtl/sparse_reduced_cost_engine.sv -----
// ----------------------------------------------------------------------------
// sparse_reduced_cost_engine
// Simplex reduced-cost pricing over sparse columns with a row-indexed dual
// price store; Q16.16 in and out, Q32.32 saturating accumulator.
// ----------------------------------------------------------------------------
// One input word per cycle unless stalled; any mix of loads, terms, closes.
// Once a close is accepted, its result word moves through registered steps:
//   multiply, accumulate/difference and round/clip into the output register.
// Stalls on the output ripple back stage by stage; bubbles are squeezed out.
// Reset clears the accumulator and pipeline valids; the price store is not
//   cleared, a row must be loaded before a term reads it.
// ----------------------------------------------------------------------------
module sparse_reduced_cost_engine #(
    parameter int ROWS = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srce_in_if.sink    i_in,
    srce_out_if.source o_res
);
    import srce_pkg::*;

    `include "sparse_reduced_cost_engine_macros.svh"

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // handshake and stage control
    logic      accept;
    logic      take1;
    logic      row_ok;
    logic      free_out, go3, free3, go2, free2, go1, free1;
    t_stage_en en;

    logic r_v1, r_close1, r_v2, r_close2, r_v3, r_out_v;

    // stage 1 payload
    logic r_ok1;
    t_val r_coef1;
    t_val r_cost1;
    t_tag r_tag1;

    t_val price;
    t_acc diff;
    logic diff_clip;
    t_tag diff_tag;

    assign row_ok = {20'd0, i_in.row_index} < 32'(ROWS);

    // ready chain from the output back to the input
    always_comb begin
        free_out = !r_out_v || o_res.ready;
        go3      = r_v3 && free_out;
        free3    = !r_v3 || free_out;
        go2      = r_v2 && (!r_close2 || free3);
        free2    = !r_v2 || go2;
        go1      = r_v1 && free2;
        free1    = !r_v1 || go1;
        accept   = i_in.valid && free1;
        take1    = accept && ((i_in.cmd == CMD_TERM) || (i_in.cmd == CMD_CLOSE));
        en.s2_load  = go1;
        en.s2_term  = go2 && !r_close2;
        en.s2_close = go2 && r_close2;
        en.s3_load  = go2 && r_close2;
        en.out_load = go3;
    end

    assign i_in.ready = free1;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_close1 <= 1'b0;
            r_v2     <= 1'b0;
            r_close2 <= 1'b0;
            r_v3     <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (take1) begin
                r_v1     <= 1'b1;
                r_close1 <= (i_in.cmd == CMD_CLOSE);
            end else if (go1) begin
                r_v1 <= 1'b0;
            end
            if (go1) begin
                r_v2     <= 1'b1;
                r_close2 <= r_close1;
            end else if (go2) begin
                r_v2 <= 1'b0;
            end
            if (en.s3_load) begin
                r_v3 <= 1'b1;
            end else if (go3) begin
                r_v3 <= 1'b0;
            end
            if (go3) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // stage 1 payload capture
    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_ok1   <= row_ok;
            r_coef1 <= i_in.coefficient;
            r_cost1 <= i_in.cost;
            r_tag1  <= i_in.var_tag;
        end
    end

    srce_price_mem #(
        .ROWS (ROWS),
        .AW   (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_in.cmd == CMD_LOAD) && row_ok),
        .i_wr_addr (AW'(i_in.row_index)),
        .i_wr_data (i_in.dual_price),
        .i_rd_en   (accept && (i_in.cmd == CMD_TERM)),
        .i_rd_addr (AW'(i_in.row_index)),
        .o_rd_data (price)
    );

    srce_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_price  (price),
        .i_coef   (r_coef1),
        .i_row_ok (r_ok1),
        .i_cost   (r_cost1),
        .i_tag    (r_tag1),
        .o_diff   (diff),
        .o_clip   (diff_clip),
        .o_tag    (diff_tag)
    );

    srce_round u_round (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_diff (diff),
        .i_clip (diff_clip),
        .i_tag  (diff_tag),
        .o_var  (o_res.out_var),
        .o_cost (o_res.reduced_cost),
        .o_sat  (o_res.saturated)
    );

    assign o_res.valid = r_out_v;

    // checks
    `SRCE_ASSERT_IMP(a_close_has_room, i_clk, i_rst_n, en.s2_close, free3, "close into full stage 3")
    `SRCE_ASSERT_NXT(a_s3_holds, i_clk, i_rst_n, r_v3 && !go3, r_v3, "stage 3 word dropped")
    `SRCE_ASSERT_NXT(a_term_enters, i_clk, i_rst_n, accept && (i_in.cmd == CMD_TERM), r_v1 && !r_close1, "term lost")

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sparse_reduced_cost_engine: price loads, sparse
// column terms and column closes go in on a valid/ready channel; a scoreboard
// predicts each reduced cost in Q32.32 / Q16.16 and checks the result words.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import srce_pkg::*;

    localparam int NUM_ROWS    = 4096;
    localparam int ITEM_TARGET = 1100;
    localparam int QUIET_AFTER = 900;
    localparam int HOLD_AT     = 350;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT    = 700;
    localparam int CYCLE_LIMIT = 200000;

    // one expected result word
    typedef struct {
        t_tag tag;
        t_val rcost;
        logic sat;
    } t_rc_word;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the price store and the column accumulator
    // ------------------------------------------------------------------------
    class reduced_cost_scoreboard;
        t_val     price_mem [NUM_ROWS];
        t_acc     col_sum;
        bit       col_clipped;
        t_rc_word pending_costs [$];
        int       errors;

        function new();
            col_sum     = '0;
            col_clipped = 1'b0;
            errors      = 0;
        endfunction

        // a + b or a - b in 65 bits, clipped back to 64
        function automatic t_acc clip_acc(logic [64:0] wide, ref bit clipped);
            if (wide[64] != wide[63]) begin
                clipped = 1'b1;
                return wide[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
            end
            return wide[63:0];
        endfunction

        // note an accepted input word
        function void note_word(t_cmd cmd, t_row row, t_val price, t_val coef, t_val cost,
                                t_tag tag);
            t_acc        a, b, prod, cost_q, diff, q;
            bit          clipped;
            t_rc_word    w;
            case (cmd)
                CMD_LOAD: begin
                    price_mem[row] = price;
                end
                CMD_TERM: begin
                    a    = price_mem[row];
                    b    = coef;
                    prod = a * b;
                    col_sum = clip_acc({col_sum[63], col_sum} + {prod[63], prod},
                                       col_clipped);
                end
                CMD_CLOSE: begin
                    clipped = col_clipped;
                    cost_q  = cost;
                    cost_q  = cost_q <<< FRAC_W;
                    diff    = clip_acc({cost_q[63], cost_q} - {col_sum[63], col_sum},
                                       clipped);
                    // round to nearest, ties toward plus infinity
                    q = diff >>> FRAC_W;
                    if (diff[FRAC_W-1])
                        q = q + 1;
                    if (q[63:31] != {33{q[63]}}) begin
                        clipped = 1'b1;
                        w.rcost = q[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end else begin
                        w.rcost = q[31:0];
                    end
                    w.tag = tag;
                    w.sat = clipped;
                    pending_costs.push_back(w);
                    col_sum     = '0;
                    col_clipped = 1'b0;
                end
                default: ;  // unused command does nothing
            endcase
        endfunction

        // check a result word against the oldest expectation
        function void check_result(t_tag tag, t_val rcost, logic sat);
            t_rc_word w;
            if (pending_costs.size() == 0) begin
                $display("%0t: unexpected result var=%0d cost=%h sat=%b",
                         $time, tag, rcost, sat);
                errors++;
                return;
            end
            w = pending_costs.pop_front();
            if (tag !== w.tag) begin
                $display("%0t: out_var expected %h actual %h", $time, w.tag, tag);
                errors++;
            end
            if (rcost !== w.rcost) begin
                $display("%0t: reduced_cost expected %h actual %h", $time, w.rcost, rcost);
                errors++;
            end
            if (sat !== w.sat) begin
                $display("%0t: saturated expected %b actual %b", $time, w.sat, sat);
                errors++;
            end
        endfunction

        function int waiting();
            return pending_costs.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    srce_in_if  in_ch ();
    srce_out_if res_ch ();

    sparse_reduced_cost_engine #(.ROWS(NUM_ROWS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    reduced_cost_scoreboard sb = new();

    int   item_count;
    int   cycle_count;
    bit   idle_en;
    bit   hold_req;
    t_row loaded_rows [$];
    bit   row_loaded [NUM_ROWS];

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // known values on every input from time zero
    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_NONE;
        in_ch.row_index   = '0;
        in_ch.dual_price  = '0;
        in_ch.coefficient = '0;
        in_ch.cost        = '0;
        in_ch.var_tag     = '0;
        res_ch.ready      = 1'b0;
        item_count        = 0;
        cycle_count       = 0;
        idle_en           = 1'b0;
        hold_req          = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.out_var, res_ch.reduced_cost, res_ch.saturated);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // drive one word, wait for the handshake, note it
    task automatic send_word(t_cmd cmd, t_row row, t_val price, t_val coef, t_val cost,
                             t_tag tag);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.row_index   <= row;
        in_ch.dual_price  <= price;
        in_ch.coefficient <= coef;
        in_ch.cost        <= cost;
        in_ch.var_tag     <= tag;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(cmd, row, price, coef, cost, tag);
        if (cmd != CMD_NONE)
            item_count++;
    endtask

    task automatic load_price(t_row row, t_val price);
        send_word(CMD_LOAD, row, price, $urandom, $urandom, t_tag'($urandom));
        if (!row_loaded[row]) begin
            row_loaded[row] = 1'b1;
            loaded_rows.push_back(row);
        end
    endtask

    task automatic add_term(t_row row, t_val coef);
        send_word(CMD_TERM, row, $urandom, coef, $urandom, t_tag'($urandom));
    endtask

    task automatic close_column(t_val cost, t_tag tag);
        send_word(CMD_CLOSE, t_row'($urandom), $urandom, $urandom, cost, tag);
    endtask

    // mix of extremes, small Q16.16 values and full-range words
    function automatic t_val pick_val();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1, 2, 3, 4: return t_val'(int'($urandom_range(0, 1048576)) - 524288);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int n_terms;
        bit hold_done;
        bit drain_done;

        hold_done  = 1'b0;
        drain_done = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, empty columns, clipping and rounding ties
        load_price(12'd0,    32'h7FFF_FFFF);
        load_price(12'd4095, 32'h8000_0000);
        load_price(12'd1,    32'h0001_0000);   // 1.0
        load_price(12'd2,    32'hFFFE_8000);   // -1.5
        load_price(12'd3,    32'h0000_0001);   // one LSB
        close_column(32'h7FFF_FFFF, 16'hFFFF); // empty column keeps its cost
        close_column(32'h8000_0000, 16'h0000);
        add_term(12'd1, 32'h0002_0000);
        add_term(12'd2, 32'h0000_8000);
        send_word(CMD_NONE, t_row'($urandom), $urandom, $urandom, $urandom, t_tag'($urandom));
        close_column(32'h0003_0000, 16'h0001);
        // accumulator clips high
        add_term(12'd4095, 32'h8000_0000);
        add_term(12'd4095, 32'h8000_0000);
        close_column(32'h0000_0000, 16'h0002);
        // accumulator clips low
        add_term(12'd4095, 32'h7FFF_FFFF);
        add_term(12'd4095, 32'h7FFF_FFFF);
        add_term(12'd4095, 32'h7FFF_FFFF);
        close_column(32'h8000_0000, 16'h0003);
        // difference clips, accumulator does not
        add_term(12'd0, 32'h7FFF_FFFF);
        add_term(12'd0, 32'h7FFF_FFFF);
        close_column(32'h8000_0000, 16'h0004);
        // rounding ties, negative then positive
        add_term(12'd3, 32'h0000_8000);
        close_column(32'h0000_0000, 16'h0005);
        add_term(12'd3, 32'hFFFF_8000);
        close_column(32'h0000_0000, 16'h0006);

        // random: mostly whole columns over loaded rows, some loads and noise
        idle_en = 1'b1;
        while (item_count < ITEM_TARGET) begin
            if (item_count >= QUIET_AFTER)
                idle_en = 1'b0;
            else if ($urandom_range(0, 39) == 0)
                idle_en = ($urandom_range(0, 3) != 0);

            // one long receiver hold-off
            if (!hold_done && item_count >= HOLD_AT) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end

            if (!drain_done && item_count >= DRAIN_AT) begin
                // sender pause until every result is out
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (sb.waiting() != 0);
                drain_done = 1'b1;
            end

            case ($urandom_range(0, 19))
                0, 1, 2: load_price(t_row'($urandom_range(0, NUM_ROWS - 1)), pick_val());
                3: send_word(CMD_NONE, t_row'($urandom), $urandom, $urandom, $urandom,
                             t_tag'($urandom));
                default: begin
                    n_terms = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 9);
                    repeat (n_terms) begin
                        if ($urandom_range(0, 15) == 0)
                            load_price(t_row'($urandom_range(0, NUM_ROWS - 1)), pick_val());
                        add_term(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)],
                                 pick_val());
                    end
                    close_column(pick_val(), t_tag'($urandom));
                end
            endcase
        end
        in_ch.valid <= 1'b0;

        // drain, then give the pipeline time to show anything extra
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/srce_pkg.sv
rtl/srce_ifs.sv
rtl/srce_price_mem.sv
rtl/srce_mac.sv
rtl/srce_round.sv
rtl/sparse_reduced_cost_engine.sv
tb/sv/testbench.sv
